// ----- rtl/wcae_pkg.sv -----
package wcae_pkg;

    // Number of CORDIC iterations run per angle.
    localparam int CordicSteps = 16;
    localparam int StepW = 5;

    // The arctangent table holds 23 entries, so more steps add nothing.
    localparam int CordicRun = (CordicSteps < 24) ? CordicSteps : 24;

    localparam logic signed [31:0] Deg90Q16 = 32'sd5898240;
    localparam logic signed [31:0] Deg180Q16 = 32'sd11796480;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_INIT,
        ST_ROT,
        ST_DONE,
        ST_OUT
    } state_t;

    // Arctangent of 2^-i in degrees, Q16.16, rounded to nearest.
    function automatic logic [21:0] atan_deg(input logic [StepW-1:0] i);
        logic [21:0] r;
        begin
            unique case (i)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/wall_contact_angle_extremes_unit.sv -----
// Wall contact-angle extremes.
// Input channel (valid/ready): one wall face per item with interface normal,
// wall normal, face centre x and a last_face flag. Faces with a zero interface
// normal are skipped; the leftmost and rightmost remaining faces are kept,
// ties keeping the earlier face.
// A face without last_face is taken at once, and faces may follow back
// to back while the block is idle.
// A last_face item starts the angle engine: for the left face and then the
// right face, one shared 32x32 multiplier forms the dot product, the cross
// terms and their squares, a bit-serial square root follows, a setup step
// loads the CORDIC, the CORDIC runs 16 steps, one per cycle, and a rounding
// step finishes the angle. The right side's computation starts once the left
// result is taken.
// Output channel (valid/ready): left result, then right result. Each result
// sits in an output register until taken; a stalled receiver holds the block
// busy and in_ready low. in_ready returns the cycle after the right result is
// taken. Reset clears the scan state and drops out_valid.
module wall_contact_angle_extremes_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] iface_normal_x,
    input  logic signed [15:0] iface_normal_y,
    input  logic signed [15:0] iface_normal_z,
    input  logic signed [15:0] wall_normal_x,
    input  logic signed [15:0] wall_normal_y,
    input  logic signed [15:0] wall_normal_z,
    input  logic signed [31:0] face_centre_x,
    input  logic               last_face,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        angle_deg,
    output logic               side,
    output logic               found,
    output logic               last_of_run
);

    wcae_pkg::state_t state_reg, state_next;

    logic               any_reg, any_next;
    logic signed [31:0] lx_reg, lx_next, rx_reg, rx_next;
    logic [47:0]        la_reg, la_next, lb_reg, lb_next;
    logic [47:0]        ra_reg, ra_next, rb_reg, rb_next;

    logic               side_reg, side_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [4:0]         it_reg, it_next;
    logic signed [32:0] dot_reg, dot_next;
    logic [31:0]        c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [35:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic signed [35:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] z_reg, z_next;
    logic               zero_reg, zero_next;

    logic [15:0]        ang_reg, ang_next;
    logic               ovalid_reg, ovalid_next;
    logic               ofound_reg, ofound_next;

    // Selected operand vectors for the current side.
    logic [47:0]        va, vb;
    logic [47:0]        face_a, face_b;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [63:0] diff;
    logic [63:0]        dabs;
    logic [31:0]        cabs;
    logic [35:0]        rem_sh, trial;
    logic [32:0]        dot_abs;
    logic [31:0]        dh;
    logic               dneg;
    logic signed [35:0] xs, ys;
    logic signed [31:0] atn;
    logic signed [31:0] zc;
    logic [15:0]        zr;
    logic               qual, take_l, take_r;

    function automatic logic signed [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    assign va = side_reg ? ra_reg : la_reg;
    assign vb = side_reg ? rb_reg : lb_reg;
    assign face_a = {iface_normal_z, iface_normal_y, iface_normal_x};
    assign face_b = {wall_normal_z, wall_normal_y, wall_normal_x};

    // Operand selection for the shared multiplier: dot terms, cross terms, squares.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cnt_reg)
            4'd0:
            begin
                ma = ext16(va[15:0]);
                mb = ext16(vb[15:0]);
            end
            4'd1:
            begin
                ma = ext16(va[31:16]);
                mb = ext16(vb[31:16]);
            end
            4'd2:
            begin
                ma = ext16(va[47:32]);
                mb = ext16(vb[47:32]);
            end
            4'd3:
            begin
                ma = ext16(va[31:16]);
                mb = ext16(vb[47:32]);
            end
            4'd4:
            begin
                ma = ext16(va[47:32]);
                mb = ext16(vb[31:16]);
            end
            4'd5:
            begin
                ma = ext16(va[47:32]);
                mb = ext16(vb[15:0]);
            end
            4'd6:
            begin
                ma = ext16(va[15:0]);
                mb = ext16(vb[47:32]);
            end
            4'd7:
            begin
                ma = ext16(va[15:0]);
                mb = ext16(vb[31:16]);
            end
            4'd8:
            begin
                ma = ext16(va[31:16]);
                mb = ext16(vb[15:0]);
            end
            4'd9:
            begin
                ma = $signed(c0_reg);
                mb = $signed(c0_reg);
            end
            4'd10:
            begin
                ma = $signed(c1_reg);
                mb = $signed(c1_reg);
            end
            4'd11:
            begin
                ma = $signed(c2_reg);
                mb = $signed(c2_reg);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    // Halved magnitude of a cross-product component.
    assign diff = acc_reg - prod;
    assign dabs = diff[63] ? -diff : diff;
    assign cabs = dabs[32:1];

    // One digit of the square root per cycle.
    assign rem_sh = {rem_reg[33:0], acc_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};

    // Halved dot product; a value that halves to zero counts as not negative.
    assign dot_abs = dot_reg[32] ? -dot_reg : dot_reg;
    assign dh = dot_abs[32:1];
    assign dneg = dot_reg[32] && (dh != '0);

    assign xs = cx_reg >>> it_reg;
    assign ys = cy_reg >>> it_reg;
    assign atn = {10'd0, wcae_pkg::atan_deg(it_reg)};

    assign qual = (iface_normal_x != 0) || (iface_normal_y != 0) || (iface_normal_z != 0);
    assign take_l = !any_reg || (face_centre_x < lx_reg);
    assign take_r = !any_reg || (face_centre_x > rx_reg);

    // Clamp and round the final angle.
    always_comb
    begin
        zc = z_reg;
        if (z_reg < 0)
            zc = '0;
        else if (z_reg > wcae_pkg::Deg180Q16)
            zc = wcae_pkg::Deg180Q16;
        zr = 16'((zc + 32'sd128) >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wcae_pkg::ST_IDLE;
            any_reg    <= 1'b0;
            lx_reg     <= '0;
            rx_reg     <= '0;
            la_reg     <= '0;
            lb_reg     <= '0;
            ra_reg     <= '0;
            rb_reg     <= '0;
            ovalid_reg <= 1'b0;
            side_reg   <= 1'b0;
            cnt_reg    <= '0;
            it_reg     <= '0;
            dot_reg    <= '0;
            c0_reg     <= '0;
            c1_reg     <= '0;
            c2_reg     <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            z_reg      <= '0;
            zero_reg   <= 1'b0;
            ang_reg    <= '0;
            ofound_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            any_reg    <= any_next;
            lx_reg     <= lx_next;
            rx_reg     <= rx_next;
            la_reg     <= la_next;
            lb_reg     <= lb_next;
            ra_reg     <= ra_next;
            rb_reg     <= rb_next;
            ovalid_reg <= ovalid_next;
            side_reg   <= side_next;
            cnt_reg    <= cnt_next;
            it_reg     <= it_next;
            dot_reg    <= dot_next;
            c0_reg     <= c0_next;
            c1_reg     <= c1_next;
            c2_reg     <= c2_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            z_reg      <= z_next;
            zero_reg   <= zero_next;
            ang_reg    <= ang_next;
            ofound_reg <= ofound_next;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        any_next    = any_reg;
        lx_next     = lx_reg;
        rx_next     = rx_reg;
        la_next     = la_reg;
        lb_next     = lb_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        side_next   = side_reg;
        cnt_next    = cnt_reg;
        it_next     = it_reg;
        dot_next    = dot_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        c2_next     = c2_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        z_next      = z_reg;
        zero_next   = zero_reg;
        ang_next    = ang_reg;
        ovalid_next = ovalid_reg;
        ofound_next = ofound_reg;
        in_ready    = 1'b0;

        unique case (state_reg)
            wcae_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (qual)
                    begin
                        any_next = 1'b1;
                        if (take_l)
                        begin
                            lx_next = face_centre_x;
                            la_next = face_a;
                            lb_next = face_b;
                        end
                        if (take_r)
                        begin
                            rx_next = face_centre_x;
                            ra_next = face_a;
                            rb_next = face_b;
                        end
                    end
                    if (last_face)
                    begin
                        side_next = 1'b0;
                        cnt_next = '0;
                        state_next = wcae_pkg::ST_MUL;
                    end
                end
            end

            // Dot product, cross-product magnitudes and the sum of their squares.
            wcae_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + 4'd1;
                unique case (cnt_reg)
                    4'd0:
                        dot_next = 33'(prod);
                    4'd1, 4'd2:
                        dot_next = dot_reg + 33'(prod);
                    4'd3, 4'd5, 4'd7, 4'd9:
                        acc_next = prod;
                    4'd4:
                        c0_next = cabs;
                    4'd6:
                        c1_next = cabs;
                    4'd8:
                        c2_next = cabs;
                    4'd10:
                        acc_next = acc_reg + prod;
                    default:
                    begin
                        acc_next = acc_reg + prod;
                        rem_next = '0;
                        root_next = '0;
                        it_next = '0;
                        state_next = wcae_pkg::ST_SQRT;
                    end
                endcase
            end

            // Floor square root, two radicand bits per cycle.
            wcae_pkg::ST_SQRT:
            begin
                acc_next = {acc_reg[61:0], 2'b00};
                it_next = it_reg + 5'd1;
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    root_next = {root_reg[30:0], 1'b0};
                end
                if (it_reg == 5'd31)
                begin
                    it_next = '0;
                    state_next = wcae_pkg::ST_INIT;
                end
            end

            // A negative dot product is first turned by 90 degrees.
            wcae_pkg::ST_INIT:
            begin
                if (dneg)
                begin
                    cx_next = $signed({4'd0, root_reg});
                    cy_next = $signed({4'd0, dh});
                    z_next = wcae_pkg::Deg90Q16;
                end
                else
                begin
                    cx_next = $signed({4'd0, dh});
                    cy_next = $signed({4'd0, root_reg});
                    z_next = '0;
                end
                zero_next = (dh == '0) && (root_reg == '0);
                it_next = '0;
                state_next = wcae_pkg::ST_ROT;
            end

            // One CORDIC vectoring step per cycle.
            wcae_pkg::ST_ROT:
            begin
                it_next = it_reg + 5'd1;
                if (!cy_reg[35])
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next = z_reg + atn;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next = z_reg - atn;
                end
                if (it_reg == 5'(wcae_pkg::CordicRun - 1))
                begin
                    it_next = '0;
                    state_next = wcae_pkg::ST_DONE;
                end
            end

            // An undefined angle, both products zero, reads as zero.
            wcae_pkg::ST_DONE:
            begin
                ang_next = zero_reg ? 16'd0 : zr;
                ofound_next = any_reg;
                ovalid_next = 1'b1;
                state_next = wcae_pkg::ST_OUT;
            end

            // Hold the result until taken; the right side then ends the scan.
            wcae_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    ovalid_next = 1'b0;
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                        cnt_next = '0;
                        state_next = wcae_pkg::ST_MUL;
                    end
                    else
                    begin
                        side_next = 1'b0;
                        any_next = 1'b0;
                        lx_next = '0;
                        rx_next = '0;
                        la_next = '0;
                        lb_next = '0;
                        ra_next = '0;
                        rb_next = '0;
                        state_next = wcae_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = wcae_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = ovalid_reg;
    assign angle_deg   = ang_reg;
    assign side        = side_reg;
    assign found       = ofound_reg;
    assign last_of_run = side_reg;

endmodule
